// ----- rtl/lqr_pkg.sv -----
// shared types and constants for the large angle quadrant reduction pipeline
// holds the 2/pi bit string, the pi/2 multiplier and the stage payload structs
package lqr_pkg;

  localparam int PIPE_DEPTH = 8;

  localparam logic [255:0] TPI_BITS = {
    32'hA2F9836E, 32'h4E441529, 32'hFC2757D1, 32'hF534DDC0,
    32'hDB629599, 32'h3C439041, 32'hFE5163AB, 32'hDEBBC561
  };

  // 2/pi with zeros above the binary point, first bit after the point at bit 255
  localparam logic [511:0] TPI_EXT = {256'd0, TPI_BITS};

  localparam logic [31:0] PIO2 = 32'hC90FDAA2;
  localparam logic [23:0] IMPLICIT_BIT = 24'h800000;
  localparam logic [8:0] WIN_BASE = 9'd312;

  typedef struct packed {
    logic        sign;
    logic [23:0] mant;
    logic [95:0] win;
  } win_t;

  typedef struct packed {
    logic        sign;
    logic [65:0] hi;
  } fix_t;

  typedef struct packed {
    logic        sign;
    logic        neg;
    logic [1:0]  q;
    logic        zero;
    logic [5:0]  sh;
    logic [31:0] top;
  } nrm_t;

  typedef struct packed {
    logic [1:0]  q;
    logic [31:0] bits;
  } res_t;

endpackage

// ----- rtl/lqr_window.sv -----
// first stage: picks the 96-bit window of 2/pi chosen by the exponent
// depends on lqr_pkg
module lqr_window import lqr_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] x_bits,
  output win_t        win_out
);

  logic [8:0] off;

  assign off = WIN_BASE - {1'b0, x_bits[30:23]};

  always_ff @(posedge clk) begin
    if (en) begin
      win_out.sign <= x_bits[31];
      win_out.mant <= IMPLICIT_BIT | {1'b0, x_bits[22:0]};
      win_out.win  <= TPI_EXT[off +: 96];
    end
  end

endmodule

// ----- rtl/lqr_mul.sv -----
// second and third stages: 24x96 product as three registered partial products
// and their sum, keeping the quadrant bits and 64 fraction bits; depends on lqr_pkg
module lqr_mul import lqr_pkg::*; (
  input  logic clk,
  input  logic en,
  input  win_t win_in,
  output fix_t fix_out
);

  logic [55:0] pp0;
  logic [55:0] pp1;
  logic [55:0] pp2;
  logic        sign_b;
  logic [95:0] sum;

  always_ff @(posedge clk) begin
    if (en) begin
      pp0    <= {32'd0, win_in.mant} * {24'd0, win_in.win[95:64]};
      pp1    <= {32'd0, win_in.mant} * {24'd0, win_in.win[63:32]};
      pp2    <= {32'd0, win_in.mant} * {24'd0, win_in.win[31:0]};
      sign_b <= win_in.sign;
    end
  end

  assign sum = {pp0[31:0], 64'd0} + {8'd0, pp1, 32'd0} + {40'd0, pp2};

  always_ff @(posedge clk) begin
    if (en) begin
      fix_out.sign <= sign_b;
      fix_out.hi   <= sum[95:30];
    end
  end

endmodule

// ----- rtl/lqr_norm.sv -----
// stages four to six: rounds to the nearest quadrant, takes the fraction
// magnitude, counts leading zeros and normalizes; depends on lqr_pkg
module lqr_norm import lqr_pkg::*; (
  input  logic clk,
  input  logic en,
  input  fix_t fix_in,
  output nrm_t nrm_out
);

  logic        d_sign;
  logic        d_neg;
  logic [1:0]  d_q;
  logic [63:0] d_mag;

  logic        e_sign;
  logic        e_neg;
  logic [1:0]  e_q;
  logic        e_zero;
  logic [5:0]  e_sh;
  logic [63:0] e_mag;

  logic [5:0]  lz;
  logic [63:0] shifted;

  always_ff @(posedge clk) begin
    if (en) begin
      d_sign <= fix_in.sign;
      d_neg  <= fix_in.hi[63];
      d_q    <= fix_in.hi[65:64] + {1'b0, fix_in.hi[63]};
      d_mag  <= fix_in.hi[63] ? (64'd0 - fix_in.hi[63:0]) : fix_in.hi[63:0];
    end
  end

  // position of the highest set bit, as a left shift count
  always_comb begin
    lz = '0;
    for (int i = 0; i < 64; i++) begin
      if (d_mag[i]) begin
        lz = 6'(63 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_sign <= d_sign;
      e_neg  <= d_neg;
      e_q    <= d_q;
      e_zero <= (d_mag == 64'd0);
      e_sh   <= lz;
      e_mag  <= d_mag;
    end
  end

  assign shifted = e_mag << e_sh;

  always_ff @(posedge clk) begin
    if (en) begin
      nrm_out.sign <= e_sign;
      nrm_out.neg  <= e_neg;
      nrm_out.q    <= e_q;
      nrm_out.zero <= e_zero;
      nrm_out.sh   <= e_sh;
      nrm_out.top  <= shifted[63:32];
    end
  end

endmodule

// ----- rtl/lqr_round.sv -----
// last two stages: scales the fraction by pi/2 and rounds to single
// with round-to-nearest-even, then applies the input sign; depends on lqr_pkg
module lqr_round import lqr_pkg::*; (
  input  logic clk,
  input  logic en,
  input  nrm_t nrm_in,
  output res_t res_out
);

  nrm_t        g;
  logic [63:0] prod;

  logic        p31;
  logic [23:0] mant24;
  logic        guard;
  logic        sticky;
  logic        inc;
  logic [24:0] mant25;
  logic [7:0]  expo;
  logic        rsign;
  logic [31:0] rbits;

  assign prod = {32'd0, nrm_in.top} * {32'd0, PIO2};

  always_ff @(posedge clk) begin
    if (en) begin
      g.sign <= nrm_in.sign;
      g.neg  <= nrm_in.neg;
      g.q    <= nrm_in.q;
      g.zero <= nrm_in.zero;
      g.sh   <= nrm_in.sh;
      g.top  <= prod[63:32];
    end
  end

  // for a nonzero fraction the scaled top is at least 2^30, so the leading one sits at bit 31 or 30
  always_comb begin
    p31    = g.top[31];
    mant24 = p31 ? g.top[31:8] : g.top[30:7];
    guard  = p31 ? g.top[7] : g.top[6];
    sticky = p31 ? (|g.top[6:0]) : (|g.top[5:0]);
    inc    = guard & (sticky | mant24[0]);
    mant25 = {1'b0, mant24} + {24'd0, inc};
    expo   = (p31 ? 8'd127 : 8'd126) + {7'd0, mant25[24]} - {2'd0, g.sh};
    rsign  = g.neg ^ g.sign;
    rbits  = g.zero ? {rsign, 31'd0} : {rsign, expo, mant25[22:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_out.q    <= g.sign ? (2'd0 - g.q) : g.q;
      res_out.bits <= rbits;
    end
  end

endmodule

// ----- rtl/large_angle_quadrant_reduction.sv -----
// large angle quadrant reduction, top level
// depends on lqr_pkg, lqr_window, lqr_mul, lqr_norm, lqr_round
//
// one stream channel in, one out; each input item is a single-precision
// argument and yields exactly one result item: the nearest quadrant of pi/2
// (mirrored for a negative argument) and the single-precision remainder
// the datapath is eight register stages: window select, partial products,
// product sum, quadrant rounding and negate, leading-zero count, normalize,
// pi/2 multiply, round and pack
// throughput is one item per cycle; the pipeline advances whenever the
// output register is empty or being taken
// when the receiver holds tready low with a result waiting, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated
// rst clears every stage valid bit; items in flight are dropped
module large_angle_quadrant_reduction import lqr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // x_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // quadrant, reduced_bits, zero pad
);

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld;
  win_t                  win;
  fix_t                  fix;
  nrm_t                  nrm;
  res_t                  res;

  assign en            = ~vld[PIPE_DEPTH-1] | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[PIPE_DEPTH-1];
  assign m_axis_tdata  = {6'd0, res.bits, res.q};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  lqr_window u_window (
    .clk     (clk),
    .en      (en),
    .x_bits  (s_axis_tdata),
    .win_out (win)
  );

  lqr_mul u_mul (
    .clk     (clk),
    .en      (en),
    .win_in  (win),
    .fix_out (fix)
  );

  lqr_norm u_norm (
    .clk     (clk),
    .en      (en),
    .fix_in  (fix),
    .nrm_out (nrm)
  );

  lqr_round u_round (
    .clk     (clk),
    .en      (en),
    .nrm_in  (nrm),
    .res_out (res)
  );

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stage occupancy");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_freeze_holds_valids: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("stage valid bits moved during a stall");

  a_remainder_below_one: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[32:25] <= 8'd126)
    else $error("remainder magnitude not below one");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0)
    else $error("padding bits of output item not zero");

endmodule

// ----- sim/large_angle_quadrant_reduction_test.sv -----
// testbench for large_angle_quadrant_reduction: drives single-precision arguments
// through the stream ports and checks quadrant and remainder against a predictor
// depends only on the block under test; the scoreboard class holds its own 2/pi bits
module large_angle_quadrant_reduction_test;

  localparam int LATENCY     = 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int CALM_ITEMS  = 400;
  localparam int BUSY_ITEMS  = 1130;

  localparam logic [31:0] CORNER_ARGS [20] = '{
    32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7F80_0000,
    32'hFF80_0000, 32'h7FC0_0000, 32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000,
    32'h3F80_0000, 32'h45BB_8000, 32'hC5BB_8000, 32'h4974_2400, 32'hC974_2400,
    32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h4B00_0000, 32'h5F00_0000, 32'hCF00_0001
  };

  class quadrant_board;
    typedef struct packed {
      logic [31:0] arg;
      logic [1:0]  quadrant;
      logic [31:0] reduced;
    } reduction_t;

    reduction_t pending[$];
    int errors;
    int accepted;
    int negatives;
    int odd_exponents;
    int zero_remainders;
    int per_quadrant[4];

    function logic [31:0] coef_word(int w);
      case (w)
        0: return 32'hA2F9836E;
        1: return 32'h4E441529;
        2: return 32'hFC2757D1;
        3: return 32'hF534DDC0;
        4: return 32'hDB629599;
        5: return 32'h3C439041;
        6: return 32'hFE5163AB;
        7: return 32'hDEBBC561;
        default: return 32'h0;
      endcase
    endfunction

    // 32 bits of 2/pi whose first bit is bit b after the binary point
    function logic [31:0] coef_slice(int b);
      int bb;
      int w;
      int s;
      logic [31:0] hi;
      logic [31:0] lo;
      bb = b + 256;
      w = bb / 32 - 8;
      s = bb % 32;
      hi = coef_word(w);
      lo = coef_word(w + 1);
      if (s == 0) return hi;
      return (hi << s) | (lo >> (32 - s));
    endfunction

    function reduction_t reduce(logic [31:0] x);
      reduction_t res;
      logic [63:0] m;
      logic [63:0] lo_prod;
      logic [63:0] mid_prod;
      logic [63:0] hi_prod;
      logic [63:0] frac;
      logic [63:0] mag;
      logic [63:0] prod;
      logic [31:0] limb;
      logic [31:0] top;
      logic [31:0] mant;
      logic [31:0] rem;
      logic [31:0] half;
      logic [31:0] bexp;
      logic [1:0] q;
      logic neg;
      int from;
      int sh;
      int p;
      int drop;
      res.arg = x;
      m = {40'd0, 1'b1, x[22:0]};
      from = int'(x[30:23]) - 152;
      lo_prod = m * {32'd0, coef_slice(from + 64)};
      mid_prod = m * {32'd0, coef_slice(from + 32)} + (lo_prod >> 32);
      hi_prod = m * {32'd0, coef_slice(from)} + (mid_prod >> 32);
      limb = hi_prod[31:0];
      frac = {limb[29:0], mid_prod[31:0], lo_prod[31:30]};
      q = limb[31:30] + {1'b0, frac[63]};
      neg = frac[63];
      mag = neg ? (64'd0 - frac) : frac;
      if (mag == 64'd0) begin
        res.reduced = 32'd0;
      end else begin
        sh = 0;
        while (!mag[63]) begin
          mag = mag << 1;
          sh++;
        end
        prod = {32'd0, mag[63:32]} * 64'h0000_0000_C90F_DAA2;
        top = prod[63:32];
        p = 31;
        while (p > 0 && !top[p]) p--;
        if (p <= 23) begin
          mant = top << (23 - p);
        end else begin
          drop = p - 23;
          rem = top & ((32'd1 << drop) - 32'd1);
          half = 32'd1 << (drop - 1);
          mant = top >> drop;
          if (rem > half || (rem == half && mant[0])) mant++;
          if (mant == 32'h0100_0000) begin
            mant = mant >> 1;
            p++;
          end
        end
        bexp = p + 96 - sh;
        res.reduced = {neg, bexp[7:0], mant[22:0]};
      end
      // negative argument mirrors the quadrant and flips the remainder sign
      if (x[31]) begin
        q = 2'd0 - q;
        res.reduced[31] = ~res.reduced[31];
      end
      res.quadrant = q;
      return res;
    endfunction

    task report_mismatch(string what);
      if (errors < 40) $display("mismatch: %s", what);
      errors++;
    endtask

    task note_input(logic [31:0] x);
      reduction_t r;
      r = reduce(x);
      pending.push_back(r);
      accepted++;
      if (x[31]) negatives++;
      if (x[30:23] < 8'd140 || x[30:23] == 8'hFF) odd_exponents++;
      if (r.reduced[30:0] == 31'd0) zero_remainders++;
      per_quadrant[r.quadrant]++;
    endtask

    task check_result(logic [39:0] data);
      reduction_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", data));
      end else begin
        want = pending.pop_front();
        if (data[1:0] !== want.quadrant)
          report_mismatch($sformatf("arg %h quadrant %0d, want %0d",
                                    want.arg, data[1:0], want.quadrant));
        if (data[33:2] !== want.reduced)
          report_mismatch($sformatf("arg %h remainder %h, want %h",
                                    want.arg, data[33:2], want.reduced));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 32'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  quadrant_board board;
  logic calm = 1'b0;
  int   stall_left = 0;
  int   cycles = 0;

  large_angle_quadrant_reduction DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  function int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function logic [31:0] random_arg();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return {1'($urandom), 8'($urandom_range(140, 254)), 23'($urandom)};
    if (r < 90) return $urandom;
    if (r < 95) return {1'($urandom), 8'hFF, 23'($urandom)};
    return {1'($urandom), 8'($urandom_range(0, 139)), 23'($urandom)};
  endfunction

  // caller is at a falling edge; returns at the falling edge after acceptance
  task send_arg(logic [31:0] x, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= x;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_input(x);
    @(negedge clk);
  endtask

  task drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (board.pending.size() != 0);
  endtask

  always @(negedge clk) begin
    if (rst || calm) begin
      m_axis_tready <= !rst;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= pick_gap();
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, board.pending.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (CORNER_ARGS[i]) send_arg(CORNER_ARGS[i], pick_gap());
    drain();

    // back to back items, no gaps on either side
    calm <= 1'b1;
    @(negedge clk);
    repeat (CALM_ITEMS) send_arg(random_arg(), 0);
    drain();
    calm <= 1'b0;

    repeat (BUSY_ITEMS) send_arg(random_arg(), pick_gap());
    drain();
    repeat (2 * LATENCY) @(negedge clk);

    while (board.pending.size() != 0) begin
      board.report_mismatch($sformatf("no result for arg %h", board.pending[0].arg));
      void'(board.pending.pop_front());
    end

    $display("covered %0d arguments: %0d negative, %0d outside the large range, %0d zero",
             board.accepted, board.negatives, board.odd_exponents, board.zero_remainders);
    $display("quadrants 0..3 seen %0d %0d %0d %0d times, %0d mismatches",
             board.per_quadrant[0], board.per_quadrant[1], board.per_quadrant[2],
             board.per_quadrant[3], board.errors);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
